### rtl/mi3_pkg.sv
// Shared constants, types and the cofactor index table for the 3x3 matrix inverse unit.
// Used by matrix_inverse_3x3_unit; depends on nothing else.
package mi3_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int NELEM     = 9;
    localparam int DATA_W    = NELEM * ELEM_W;
    localparam int THR_W     = ELEM_W - 1;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int TERM_W    = 3 * ELEM_W;
    localparam int DET_W     = TERM_W + 1;
    localparam int MAG_W     = TERM_W;
    localparam int NDIV      = ELEM_W + 1;
    localparam int CMP_W     = MAG_W + NDIV;

    localparam int ST_PROD = 0;
    localparam int ST_COF  = 1;
    localparam int ST_PP   = 2;
    localparam int ST_TERM = 3;
    localparam int ST_DET  = 4;
    localparam int ST_MAG  = 5;
    localparam int ST_DIV0 = 6;
    localparam int ST_DIVL = ST_DIV0 + NDIV;
    localparam int ST_RND  = ST_DIVL + 1;
    localparam int ST_OUT  = ST_RND + 1;
    localparam int NS      = ST_OUT + 1;

    typedef logic [3:0] idx_t;

    // out element k = (x[p]*x[q] - x[r]*x[s]) / det
    localparam idx_t COF_IDX [NELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

### rtl/matrix_inverse_3x3_unit.sv
// Top level of the 3x3 matrix inverse unit: adjugate over determinant in Q16.16.
// Depends on mi3_pkg for widths, stage indices and the cofactor index table.
//
// Usage:
//   s_axis carries one matrix per item, nine signed Q16.16 elements row-major.
//   m_axis returns nine Q16.16 elements; tuser is the singular flag. A singular
//   matrix (determinant magnitude zero or below det_threshold) comes back as
//   given, with the flag set; otherwise the rounded, saturated inverse.
//   cfg writes det_threshold (reset value 1); cfg_ready is always high. Write
//   it only while no item is in flight.
// Pipeline: six stages of products, cofactors, determinant and magnitude, one
//   setup stage, 33 restoring divider stages (one quotient bit each, nine lanes
//   in parallel), round and output.
// Throughput: one item per cycle while the receiver does not stall m_axis.
// Each stage holds its own valid bit; a stage loads when it is empty or the
//   stage after it moves, so a stalled receiver fills bubbles first and then
//   holds s_axis_tready low. Nothing is lost or repeated.
// Reset clears all valid bits and sets det_threshold to 1.
module matrix_inverse_3x3_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2, 32 bits each
    input  logic [mi3_pkg::DATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ... out_r2c2, 32 bits each
    output logic [mi3_pkg::DATA_W-1:0]  m_axis_tdata,
    // singular
    output logic                        m_axis_tuser,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mi3_pkg::THR_W-1:0]   cfg_data
);
    import mi3_pkg::*;

    logic [NS-1:0]      v_reg;
    logic [NS:0]        rdy;
    logic [THR_W-1:0]   thr_reg;

    logic [ELEM_W-1:0]         el_reg   [0:NS-1][0:NELEM-1];
    logic signed [PROD_W-1:0]  prod_reg [0:2*NELEM-1];
    logic signed [PROD_W-1:0]  cof_reg  [ST_COF:ST_MAG-1][0:NELEM-1];
    logic signed [PROD_W-1:0]  pp_reg   [0:5];
    logic signed [TERM_W-1:0]  term_reg [0:2];
    logic signed [DET_W-1:0]   det_reg;
    logic [MAG_W-1:0]          num_reg  [0:NELEM-1];
    logic [MAG_W-1:0]          dv_reg   [ST_MAG:ST_DIVL];
    logic                      sing_reg [ST_MAG:NS-1];
    logic [NELEM-1:0]          neg_reg  [ST_MAG:ST_RND];
    logic [NELEM-1:0]          sat_reg  [ST_DIV0:ST_DIVL];
    logic [MAG_W-1:0]          rem_reg  [ST_DIV0:ST_DIVL][0:NELEM-1];
    logic [NDIV-1:0]           quo_reg  [ST_DIV0:ST_DIVL][0:NELEM-1];
    logic [ELEM_W-1:0]         mag_reg  [0:NELEM-1];
    logic [ELEM_W-1:0]         res_reg  [0:NELEM-1];

    logic signed [ELEM_W-1:0]  x        [0:NELEM-1];
    logic signed [PROD_W-1:0]  prod_next[0:2*NELEM-1];
    logic signed [PROD_W-1:0]  cof_next [0:NELEM-1];
    logic signed [PROD_W-1:0]  pp_next  [0:5];
    logic signed [TERM_W-1:0]  term_next[0:2];
    logic signed [DET_W-1:0]   det_next;
    logic [MAG_W-1:0]          dmag_next;
    logic                      sing_next;
    logic [NELEM-1:0]          neg_next;
    logic [MAG_W-1:0]          num_next [0:NELEM-1];
    logic [NELEM-1:0]          sat_next;
    logic [MAG_W-1:0]          rem_next [ST_DIV0+1:ST_DIVL][0:NELEM-1];
    logic [NDIV-1:0]           quo_next [ST_DIV0+1:ST_DIVL][0:NELEM-1];
    logic [ELEM_W-1:0]         mag_next [0:NELEM-1];
    logic [ELEM_W-1:0]         res_next [0:NELEM-1];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = v_reg[NS-1];
    assign m_axis_tuser  = sing_reg[NS-1];

    always_comb
    begin
        for (int k = 0; k < NELEM; k++)
        begin
            m_axis_tdata[k*ELEM_W +: ELEM_W] = res_reg[k];
        end
    end

    // ready chain: a stage loads when empty or when its successor moves
    always_comb
    begin
        rdy[NS] = m_axis_tready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            thr_reg <= THR_W'(1);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if (rdy[0])
            begin
                v_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end
        end
    end

    // products, cofactors, determinant partial products and sum
    always_comb
    begin
        logic signed [PROD_W:0] plw;
        for (int k = 0; k < NELEM; k++)
        begin
            x[k] = $signed(s_axis_tdata[k*ELEM_W +: ELEM_W]);
        end
        for (int k = 0; k < NELEM; k++)
        begin
            prod_next[2*k]     = x[COF_IDX[k][0]] * x[COF_IDX[k][1]];
            prod_next[2*k + 1] = x[COF_IDX[k][2]] * x[COF_IDX[k][3]];
            cof_next[k]        = prod_reg[2*k] - prod_reg[2*k + 1];
        end
        for (int t = 0; t < 3; t++)
        begin
            plw = $signed(el_reg[ST_COF][t])
                * $signed({1'b0, cof_reg[ST_COF][3*t][ELEM_W-1:0]});
            pp_next[2*t]     = plw[PROD_W-1:0];
            pp_next[2*t + 1] = $signed(el_reg[ST_COF][t])
                             * $signed(cof_reg[ST_COF][3*t][PROD_W-1:ELEM_W]);
            term_next[t] = $signed({pp_reg[2*t + 1], {ELEM_W{1'b0}}})
                         + $signed({{ELEM_W{pp_reg[2*t][PROD_W-1]}}, pp_reg[2*t]});
        end
        det_next = DET_W'(term_reg[0]) + DET_W'(term_reg[1]) + DET_W'(term_reg[2]);
    end

    // magnitude, singular test, numerators
    always_comb
    begin
        logic [DET_W-1:0]  dneg;
        logic [PROD_W-1:0] cm;
        dneg      = -det_reg;
        dmag_next = det_reg[DET_W-1] ? dneg[MAG_W-1:0] : det_reg[MAG_W-1:0];
        sing_next = (dmag_next == '0)
                 || (dmag_next < (MAG_W'(thr_reg) << (2 * FRAC_BITS)));
        for (int k = 0; k < NELEM; k++)
        begin
            cm          = cof_reg[ST_DET][k][PROD_W-1] ? PROD_W'(-cof_reg[ST_DET][k])
                                                       : cof_reg[ST_DET][k];
            num_next[k] = MAG_W'(cm) << (2 * FRAC_BITS);
            neg_next[k] = cof_reg[ST_DET][k][PROD_W-1] ^ det_reg[DET_W-1];
            sat_next[k] = {{NDIV{1'b0}}, num_reg[k]} >= ({{NDIV{1'b0}}, dv_reg[ST_MAG]} << NDIV);
        end
    end

    // restoring divider: one quotient bit per stage, most significant first
    always_comb
    begin
        logic [CMP_W-1:0] dsh;
        for (int s = ST_DIV0 + 1; s <= ST_DIVL; s++)
        begin
            dsh = {{NDIV{1'b0}}, dv_reg[s - 1]} << (ST_DIVL - s);
            for (int k = 0; k < NELEM; k++)
            begin
                rem_next[s][k] = rem_reg[s - 1][k];
                quo_next[s][k] = quo_reg[s - 1][k];
                if ({{NDIV{1'b0}}, rem_reg[s - 1][k]} >= dsh)
                begin
                    rem_next[s][k] = rem_reg[s - 1][k] - dsh[MAG_W-1:0];
                    quo_next[s][k][ST_DIVL - s] = 1'b1;
                end
            end
        end
    end

    // round to nearest, saturate, apply sign; a singular matrix passes its input through
    always_comb
    begin
        logic [NDIV:0] q_rnd;
        logic [NDIV:0] maxmag;
        logic          rnd;
        for (int k = 0; k < NELEM; k++)
        begin
            rnd    = {rem_reg[ST_DIVL][k], 1'b0} >= {1'b0, dv_reg[ST_DIVL]};
            q_rnd  = {1'b0, quo_reg[ST_DIVL][k]} + (NDIV + 1)'(rnd);
            maxmag = neg_reg[ST_DIVL][k] ? ((NDIV + 1)'(1) << (ELEM_W - 1))
                                         : (((NDIV + 1)'(1) << (ELEM_W - 1)) - 1'b1);
            mag_next[k] = (sat_reg[ST_DIVL][k] || q_rnd > maxmag) ? maxmag[ELEM_W-1:0]
                                                                  : q_rnd[ELEM_W-1:0];
            if (sing_reg[ST_RND])
            begin
                res_next[k] = el_reg[ST_RND][k];
            end
            else
            begin
                res_next[k] = neg_reg[ST_RND][k] ? -mag_reg[k] : mag_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_PROD])
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                el_reg[ST_PROD][k] <= s_axis_tdata[k*ELEM_W +: ELEM_W];
            end
            for (int k = 0; k < 2 * NELEM; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        for (int s = 1; s < NS; s++)
        begin
            if (rdy[s])
            begin
                for (int k = 0; k < NELEM; k++)
                begin
                    el_reg[s][k] <= el_reg[s - 1][k];
                end
            end
        end
        if (rdy[ST_COF])
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                cof_reg[ST_COF][k] <= cof_next[k];
            end
        end
        for (int s = ST_COF + 1; s < ST_MAG; s++)
        begin
            if (rdy[s])
            begin
                for (int k = 0; k < NELEM; k++)
                begin
                    cof_reg[s][k] <= cof_reg[s - 1][k];
                end
            end
        end
        if (rdy[ST_PP])
        begin
            for (int k = 0; k < 6; k++)
            begin
                pp_reg[k] <= pp_next[k];
            end
        end
        if (rdy[ST_TERM])
        begin
            for (int t = 0; t < 3; t++)
            begin
                term_reg[t] <= term_next[t];
            end
        end
        if (rdy[ST_DET])
        begin
            det_reg <= det_next;
        end
        if (rdy[ST_MAG])
        begin
            dv_reg[ST_MAG]   <= dmag_next;
            sing_reg[ST_MAG] <= sing_next;
            neg_reg[ST_MAG]  <= neg_next;
            for (int k = 0; k < NELEM; k++)
            begin
                num_reg[k] <= num_next[k];
            end
        end
        if (rdy[ST_DIV0])
        begin
            sat_reg[ST_DIV0] <= sat_next;
            for (int k = 0; k < NELEM; k++)
            begin
                rem_reg[ST_DIV0][k] <= num_reg[k];
                quo_reg[ST_DIV0][k] <= '0;
            end
        end
        for (int s = ST_MAG + 1; s <= ST_DIVL; s++)
        begin
            if (rdy[s])
            begin
                dv_reg[s] <= dv_reg[s - 1];
            end
        end
        for (int s = ST_DIV0 + 1; s <= ST_DIVL; s++)
        begin
            if (rdy[s])
            begin
                sat_reg[s] <= sat_reg[s - 1];
                for (int k = 0; k < NELEM; k++)
                begin
                    rem_reg[s][k] <= rem_next[s][k];
                    quo_reg[s][k] <= quo_next[s][k];
                end
            end
        end
        for (int s = ST_MAG + 1; s < NS; s++)
        begin
            if (rdy[s])
            begin
                sing_reg[s] <= sing_reg[s - 1];
            end
        end
        for (int s = ST_MAG + 1; s <= ST_RND; s++)
        begin
            if (rdy[s])
            begin
                neg_reg[s] <= neg_reg[s - 1];
            end
        end
        if (rdy[ST_RND])
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                mag_reg[k] <= mag_next[k];
            end
        end
        if (rdy[ST_OUT])
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                res_reg[k] <= res_next[k];
            end
        end
    end

endmodule
